### rtl/rpwp_pkg.sv
// Shared types and constants for the RGB pixel word packer.
// No dependencies; used by every module under rtl/.
package rpwp_pkg;

  typedef enum logic [1:0] {
    FmtBgra = 2'd0,
    FmtArgb = 2'd1,
    FmtR210 = 2'd2,
    FmtR12l = 2'd3
  } fmt_e;

  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned OutAddrWidth = 30;

  localparam logic [CfgIdxWidth-1:0] CfgIdxPixelFormat = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgIdxFrameWidth  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgIdxFrameHeight = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CfgIdxRowPitch    = 2'd3;

  localparam logic [11:0] Max8Bit  = 12'h0FF;
  localparam logic [11:0] Max10Bit = 12'h3FF;
  localparam logic [11:0] Max12Bit = 12'hFFF;
  localparam logic [7:0]  AlphaOpaque = 8'hFF;
  localparam logic [4:0]  R12lFullResidual = 5'd28;
  localparam logic [4:0]  R12lResidualStep = 5'd4;

  typedef struct packed {
    fmt_e        pixel_format;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [13:0] row_pitch_words;
  } cfg_t;

  // One queued pixel: one or two frame words with their addresses.
  typedef struct packed {
    logic [31:0]             word0;
    logic [31:0]             word1;
    logic [OutAddrWidth-1:0] addr0;
    logic [OutAddrWidth-1:0] addr1;
    logic                    two_words;
    logic                    frame_end;
  } job_t;

endpackage

### rtl/rgb_pixel_word_packer.sv
// RGB pixel word packer: pixel in, 32-bit frame words with addresses out.
// Timing: a pixel's job is registered into the job queue on its push transaction.
// Throughput: one pixel per cycle while the queue is not full; an R12L pixel that yields
//   two words holds the output port for both; a full R12L group of 8 pixels gives 9 words.
// Reset: asynchronous, active low; clears position state, residual bits and queue,
//   and loads the registers with BGRA, 1920 x 1080, pitch 480 words.
module rgb_pixel_word_packer #(
  parameter int unsigned ADDR_WIDTH  = 30,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [15:0] red_in_i,
  input  logic [15:0] green_in_i,
  input  logic [15:0] blue_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] packed_word_o,
  output logic [29:0] word_address_o,
  output logic        run_last_o,
  output logic        frame_end_o
);

  rpwp_pkg::cfg_t cfg_q;
  rpwp_pkg::job_t new_job, head_job;
  logic           accept, q_empty, q_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_format    <= rpwp_pkg::FmtBgra;
      cfg_q.frame_width     <= 16'd1920;
      cfg_q.frame_height    <= 16'd1080;
      cfg_q.row_pitch_words <= 14'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rpwp_pkg::CfgIdxPixelFormat: cfg_q.pixel_format <= rpwp_pkg::fmt_e'(cfg_data_i[1:0]);
        rpwp_pkg::CfgIdxFrameWidth:  cfg_q.frame_width  <= cfg_data_i;
        rpwp_pkg::CfgIdxFrameHeight: cfg_q.frame_height <= cfg_data_i;
        default:                     cfg_q.row_pitch_words <= cfg_data_i[13:0];
      endcase
    end
  end

  assign accept = push && !full;

  rpwp_front #(.ADDR_WIDTH(ADDR_WIDTH)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .red_i    (red_in_i),
    .green_i  (green_in_i),
    .blue_i   (blue_in_i),
    .job_o    (new_job)
  );

  rpwp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (push),
    .wr_job_i (new_job),
    .rd_i     (q_rd),
    .head_o   (head_job),
    .full_o   (full),
    .empty_o  (q_empty)
  );

  rpwp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head_job),
    .q_empty_i      (q_empty),
    .q_rd_o         (q_rd),
    .empty_o        (empty),
    .pop_i          (pop),
    .packed_word_o  (packed_word_o),
    .word_address_o (word_address_o),
    .run_last_o     (run_last_o),
    .frame_end_o    (frame_end_o)
  );

endmodule

### rtl/rpwp_front.sv
// Front end: clamps and packs one pixel per transaction, tracks row/frame position.
// Depends on rpwp_pkg (cfg_t, job_t, format codes).
module rpwp_front #(
  parameter int unsigned ADDR_WIDTH = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rpwp_pkg::cfg_t     cfg_i,
  input  logic               accept_i,
  input  logic [15:0]        red_i,
  input  logic [15:0]        green_i,
  input  logic [15:0]        blue_i,
  output rpwp_pkg::job_t     job_o
);

  localparam int unsigned AddrBits =
    (ADDR_WIDTH < rpwp_pkg::OutAddrWidth) ? ADDR_WIDTH : rpwp_pkg::OutAddrWidth;

  logic [27:0]         res_q, res_d;
  logic [4:0]          rc_q, rc_d;
  logic [15:0]         col_q, col_d;
  logic [15:0]         row_q, row_d;
  logic [13:0]         wc_q, wc_d;
  logic [AddrBits-1:0] base_q, base_d;

  logic [11:0] maxval, r, g, b;
  logic        row_end, frame_done;
  logic [63:0] acc;
  logic [35:0] pix;
  logic [9:0]  wc_step;
  logic [31:0] v210;
  logic [13:0] wc1;
  logic [AddrBits-1:0] addr0, addr1;

  function automatic logic [11:0] clamp(input logic [15:0] x, input logic [11:0] m);
    clamp = (x > {4'd0, m}) ? m : x[11:0];
  endfunction

  always_comb begin
    unique case (cfg_i.pixel_format)
      rpwp_pkg::FmtBgra, rpwp_pkg::FmtArgb: maxval = rpwp_pkg::Max8Bit;
      rpwp_pkg::FmtR210:                    maxval = rpwp_pkg::Max10Bit;
      default:                              maxval = rpwp_pkg::Max12Bit;
    endcase
    r = clamp(red_i, maxval);
    g = clamp(green_i, maxval);
    b = clamp(blue_i, maxval);

    row_end    = ({1'b0, col_q} + 17'd1) >= {1'b0, cfg_i.frame_width};
    frame_done = row_end && (({1'b0, row_q} + 17'd1) >= {1'b0, cfg_i.frame_height});

    pix  = {b, g, r};
    acc  = {36'd0, res_q} | ({28'd0, pix} << rc_q);
    v210 = {2'b00, r[9:0], g[9:0], b[9:0]};

    job_o.word0     = '0;
    job_o.word1     = '0;
    job_o.two_words = 1'b0;
    job_o.frame_end = frame_done;
    res_d = '0;
    rc_d  = '0;

    unique case (cfg_i.pixel_format)
      rpwp_pkg::FmtBgra: job_o.word0 = {rpwp_pkg::AlphaOpaque, r[7:0], g[7:0], b[7:0]};
      rpwp_pkg::FmtArgb: job_o.word0 = {b[7:0], g[7:0], r[7:0], rpwp_pkg::AlphaOpaque};
      rpwp_pkg::FmtR210: job_o.word0 = {v210[7:0], v210[15:8], v210[23:16], v210[31:24]};
      default: begin
        job_o.word0 = acc[31:0];
        if (rc_q >= rpwp_pkg::R12lFullResidual) begin
          job_o.word1     = acc[63:32];
          job_o.two_words = 1'b1;
        end else if (row_end) begin
          // partial group at row end goes out zero filled
          job_o.word1     = {4'd0, acc[59:32]};
          job_o.two_words = 1'b1;
        end else begin
          res_d = acc[59:32];
          rc_d  = rc_q + rpwp_pkg::R12lResidualStep;
        end
      end
    endcase

    wc1   = wc_q + 14'd1;
    addr0 = base_q + AddrBits'(wc_q);
    addr1 = base_q + AddrBits'(wc1);
    job_o.addr0 = rpwp_pkg::OutAddrWidth'(addr0);
    job_o.addr1 = rpwp_pkg::OutAddrWidth'(addr1);

    wc_step = job_o.two_words ? 10'd2 : 10'd1;
    if (row_end) begin
      col_d = '0;
      wc_d  = '0;
      if (frame_done) begin
        row_d  = '0;
        base_d = '0;
      end else begin
        row_d  = row_q + 16'd1;
        base_d = base_q + AddrBits'(cfg_i.row_pitch_words);
      end
    end else begin
      col_d  = col_q + 16'd1;
      wc_d   = wc_q + 14'(wc_step);
      row_d  = row_q;
      base_d = base_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q  <= '0;
      rc_q   <= '0;
      col_q  <= '0;
      row_q  <= '0;
      wc_q   <= '0;
      base_q <= '0;
    end else if (accept_i) begin
      res_q  <= res_d;
      rc_q   <= rc_d;
      col_q  <= col_d;
      row_q  <= row_d;
      wc_q   <= wc_d;
      base_q <= base_d;
    end
  end

endmodule

### rtl/rpwp_queue.sv
// Small flop-based job queue between the front end and the word sequencer.
// Depends on rpwp_pkg (job_t).
module rpwp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  rpwp_pkg::job_t wr_job_i,
  input  logic           rd_i,
  output rpwp_pkg::job_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  rpwp_pkg::job_t  mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_rd) rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

### rtl/rpwp_back.sv
// Back end: steps through the one or two words of the job at the queue head.
// Depends on rpwp_pkg (job_t).
module rpwp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rpwp_pkg::job_t head_i,
  input  logic           q_empty_i,
  output logic           q_rd_o,
  output logic           empty_o,
  input  logic           pop_i,
  output logic [31:0]    packed_word_o,
  output logic [29:0]    word_address_o,
  output logic           run_last_o,
  output logic           frame_end_o
);

  logic sub_q;
  logic take;

  assign empty_o        = q_empty_i;
  assign take           = pop_i && !q_empty_i;
  assign packed_word_o  = sub_q ? head_i.word1 : head_i.word0;
  assign word_address_o = sub_q ? head_i.addr1 : head_i.addr0;
  assign run_last_o     = sub_q || !head_i.two_words;
  assign frame_end_o    = run_last_o && head_i.frame_end;
  assign q_rd_o         = take && run_last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else if (take) begin
      sub_q <= !run_last_o;
    end
  end

  a_sub_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> (!q_empty_i && head_i.two_words))
    else $error("second word selected without a two-word job");

  a_fe_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_empty_i && frame_end_o) |-> run_last_o)
    else $error("frame end on a word that is not the last of its pixel");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && head_i.two_words && !sub_q) |=> (sub_q && !q_empty_i))
    else $error("first of two words popped but sequencer did not advance");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && sub_q) |=> !sub_q)
    else $error("sequencer stuck on second word");

endmodule
